>>> hdl/atrp_pkg.sv
// Package for the tilt angle unit: sizes, fixed-point constants, types and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package atrp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SAMPLE_BITS   = 14;
    localparam int TAB_LEN       = 24;

    localparam int SHW         = $clog2(CORDIC_STAGES);
    localparam int DIV_SHIFT   = 16 - SAMPLE_BITS;
    localparam int SCALE_SHIFT = 16;
    // Vector words hold sample * 2^16 with headroom for the CORDIC gain.
    localparam int VW   = SAMPLE_BITS + 20;
    localparam int AW   = 33;
    localparam int NUMW = SAMPLE_BITS + 18;

    localparam int ROLL_LIM      = 18000;
    localparam int PITCH_LIM     = 9000;
    localparam int ROUND_HALF    = 32768;
    localparam int HALF_TURN_Q16 = 1179648000;
    localparam int GAIN_Q16      = 107922;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] ang;
    } vec_t;

    typedef struct packed {
        sample_t               xs;
        sample_t               ys;
        sample_t               zs;
        logic signed [NUMW-1:0] num;
        logic signed [15:0]     roll;
        logic                   zero;
    } side_t;

    // atan(2^-i) in centidegrees, Q16, rounded to nearest.
    localparam logic signed [AW-1:0] ATAN_Q16 [TAB_LEN] = '{
        33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
        33'sd23437865,  33'sd11730358,  33'sd5866610,  33'sd2933484,
        33'sd1466764,   33'sd733385,    33'sd366693,   33'sd183346,
        33'sd91673,     33'sd45837,     33'sd22918,    33'sd11459,
        33'sd5730,      33'sd2865,      33'sd1432,     33'sd716,
        33'sd358,       33'sd179,       33'sd90,       33'sd45
    };

    // Signed 16-bit word divided by a power of two, truncating toward zero.
    function automatic sample_t make_sample(logic [7:0] hi, logic [7:0] lo);
        logic signed [16:0] w;
        logic signed [16:0] b;
        logic signed [16:0] t;
        w = 17'(signed'({hi, lo}));
        b = w[16] ? 17'((1 << DIV_SHIFT) - 1) : 17'sd0;
        t = (w + b) >>> DIV_SHIFT;
        return t[SAMPLE_BITS-1:0];
    endfunction

    // Q16 centidegrees to whole centidegrees, ties upward, clamped to +-lim.
    function automatic logic signed [15:0] round_centideg(logic signed [AW-1:0] a,
                                                         logic signed [15:0] lim);
        logic signed [AW-1:0]  t;
        logic signed [AW-17:0] r;
        t = a + AW'(ROUND_HALF);
        r = t[AW-1:16];
        priority if (r > lim) begin
            return lim;
        end else if (r < -lim) begin
            return -lim;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/atrp_cordic_cell.sv
// One CORDIC vectoring micro-rotation held in a pipeline register with valid and ready.
`timescale 1ns / 1ps
`default_nettype none
module atrp_cordic_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [atrp_pkg::SHW-1:0]      shift,
    input  wire logic signed [atrp_pkg::AW-1:0] atan,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire atrp_pkg::vec_t                in_vec,
    input  wire atrp_pkg::side_t               in_side,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output atrp_pkg::vec_t                     out_vec,
    output atrp_pkg::side_t                    out_side
);
    import atrp_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    vec_t                 vec_reg;
    vec_t                 vec_next;
    side_t                side_reg;
    logic signed [VW-1:0] x_in;
    logic signed [VW-1:0] y_in;
    logic signed [AW-1:0] ang_in;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        x_in   = in_vec.x;
        y_in   = in_vec.y;
        ang_in = in_vec.ang;
        dx     = y_in >>> shift;
        dy     = x_in >>> shift;
        // Both updates use the old x and y.
        if (!y_in[VW-1]) begin
            vec_next.x   = x_in + dx;
            vec_next.y   = y_in - dy;
            vec_next.ang = ang_in + atan;
        end else begin
            vec_next.x   = x_in - dx;
            vec_next.y   = y_in + dy;
            vec_next.ang = ang_in - atan;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

>>> hdl/accel_tilt_roll_pitch.sv
// Top level of the tilt angle unit: sample alignment, roll and pitch CORDIC chains, output stage.
//
// Input channel (s_): the six data bytes of one accelerometer reading, X, Y and Z, high and
// low byte each. Result channel (m_): the three aligned 14-bit samples, roll = atan2(y, z)
// and pitch = atan2(x, |(y, z)|), both in signed hundredths of a degree.
// The path is a row of register stages, each with its own valid bit: one alignment stage,
// one stage that prepares the roll vector and forms the pitch numerator with a multiplier,
// CORDIC_STAGES roll cells, one stage that rounds roll and prepares the pitch vector,
// CORDIC_STAGES pitch cells and the output register. One item is taken every cycle unless a
// stalled receiver has filled every stage and so holds s_ready low.
// Every stage moves on when the stage after it is empty or being emptied, so a stalled
// receiver fills the empty stages first; s_ready drops only once every stage is full, and
// rises again in the same cycle as m_ready, as each stage's ready is formed combinationally
// from the stage after it.
// Synchronous reset (aresetn low) empties every stage; no other state is held.
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_roll_pitch (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_x_high,
    input  wire logic [7:0]              s_x_low,
    input  wire logic [7:0]              s_y_high,
    input  wire logic [7:0]              s_y_low,
    input  wire logic [7:0]              s_z_high,
    input  wire logic [7:0]              s_z_low,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output atrp_pkg::sample_t            m_x_sample,
    output atrp_pkg::sample_t            m_y_sample,
    output atrp_pkg::sample_t            m_z_sample,
    output logic signed [15:0]           m_roll_centideg,
    output logic signed [14:0]           m_pitch_centideg
);
    import atrp_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam logic signed [AW-1:0]   HALF_Q    = AW'(HALF_TURN_Q16);
    localparam logic signed [NUMW-1:0] GAIN_N    = NUMW'(GAIN_Q16);
    localparam logic signed [15:0]     ROLL_L16  = 16'(ROLL_LIM);
    localparam logic signed [15:0]     PITCH_L16 = 16'(PITCH_LIM);

    // Alignment stage.
    logic    a_valid_reg;
    logic    a_ready;
    sample_t a_x_reg;
    sample_t a_y_reg;
    sample_t a_z_reg;

    // Roll preparation stage.
    logic  b_valid_reg;
    logic  b_ready;
    vec_t  b_vec_reg;
    vec_t  b_vec_next;
    side_t b_side_reg;
    side_t b_side_next;
    logic signed [VW-1:0] zext;
    logic signed [VW-1:0] yext;

    // Roll chain.
    logic  r_valid [N+1];
    logic  r_ready [N+1];
    vec_t  r_vec   [N+1];
    side_t r_side  [N+1];

    // Pitch preparation stage.
    logic  c_valid_reg;
    logic  c_ready;
    vec_t  c_vec_reg;
    vec_t  c_vec_next;
    side_t c_side_reg;
    side_t c_side_next;

    // Pitch chain.
    logic  p_valid [N+1];
    logic  p_ready [N+1];
    vec_t  p_vec   [N+1];
    side_t p_side  [N+1];

    // Output register.
    logic               m_valid_reg;
    logic               d_ready;
    sample_t            m_x_reg;
    sample_t            m_y_reg;
    sample_t            m_z_reg;
    logic signed [15:0] m_roll_reg;
    logic signed [14:0] m_pitch_reg;
    logic signed [15:0] pitch_full;

    assign d_ready = !m_valid_reg || m_ready;
    assign c_ready = !c_valid_reg || p_ready[0];
    assign b_ready = !b_valid_reg || r_ready[0];
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
        if (s_valid && a_ready) begin
            a_x_reg <= make_sample(s_x_high, s_x_low);
            a_y_reg <= make_sample(s_y_high, s_y_low);
            a_z_reg <= make_sample(s_z_high, s_z_low);
        end
    end

    // A negative z turns the vector half a turn so that the CORDIC starts in the right
    // half-plane; the start angle carries the half turn with the sign of y.
    always_comb begin
        zext = VW'(a_z_reg);
        yext = VW'(a_y_reg);
        b_side_next.xs   = a_x_reg;
        b_side_next.ys   = a_y_reg;
        b_side_next.zs   = a_z_reg;
        b_side_next.num  = NUMW'(a_x_reg) * GAIN_N;
        b_side_next.roll = '0;
        b_side_next.zero = (a_y_reg == '0) && (a_z_reg == '0);
        if (a_z_reg[SAMPLE_BITS-1]) begin
            b_vec_next.x   = (-zext) <<< SCALE_SHIFT;
            b_vec_next.y   = (-yext) <<< SCALE_SHIFT;
            b_vec_next.ang = a_y_reg[SAMPLE_BITS-1] ? -HALF_Q : HALF_Q;
        end else begin
            b_vec_next.x   = zext <<< SCALE_SHIFT;
            b_vec_next.y   = yext <<< SCALE_SHIFT;
            b_vec_next.ang = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (a_valid_reg && b_ready) begin
            b_vec_reg  <= b_vec_next;
            b_side_reg <= b_side_next;
        end
    end

    assign r_valid[0] = b_valid_reg;
    assign r_vec[0]   = b_vec_reg;
    assign r_side[0]  = b_side_reg;
    assign r_ready[N] = c_ready;

    for (genvar g = 0; g < N; g++) begin : g_roll
        atrp_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (SHW'(g)),
            .atan      (ATAN_Q16[g]),
            .in_valid  (r_valid[g]),
            .in_ready  (r_ready[g]),
            .in_vec    (r_vec[g]),
            .in_side   (r_side[g]),
            .out_valid (r_valid[g+1]),
            .out_ready (r_ready[g+1]),
            .out_vec   (r_vec[g+1]),
            .out_side  (r_side[g+1])
        );
    end

    // Roll is final here; the roll magnitude becomes the pitch denominator.
    always_comb begin
        c_side_next      = r_side[N];
        c_side_next.roll = r_side[N].zero ? 16'sd0 : round_centideg(r_vec[N].ang, ROLL_L16);
        c_side_next.zero = (r_side[N].num == '0) && (r_vec[N].x == '0);
        c_vec_next.x     = r_vec[N].x;
        c_vec_next.y     = VW'(r_side[N].num);
        c_vec_next.ang   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= r_valid[N];
        end
        if (r_valid[N] && c_ready) begin
            c_vec_reg  <= c_vec_next;
            c_side_reg <= c_side_next;
        end
    end

    assign p_valid[0] = c_valid_reg;
    assign p_vec[0]   = c_vec_reg;
    assign p_side[0]  = c_side_reg;
    assign p_ready[N] = d_ready;

    for (genvar g = 0; g < N; g++) begin : g_pitch
        atrp_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (SHW'(g)),
            .atan      (ATAN_Q16[g]),
            .in_valid  (p_valid[g]),
            .in_ready  (p_ready[g]),
            .in_vec    (p_vec[g]),
            .in_side   (p_side[g]),
            .out_valid (p_valid[g+1]),
            .out_ready (p_ready[g+1]),
            .out_vec   (p_vec[g+1]),
            .out_side  (p_side[g+1])
        );
    end

    assign pitch_full = p_side[N].zero ? 16'sd0 : round_centideg(p_vec[N].ang, PITCH_L16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_ready) begin
            m_valid_reg <= p_valid[N];
        end
        if (p_valid[N] && d_ready) begin
            m_x_reg     <= p_side[N].xs;
            m_y_reg     <= p_side[N].ys;
            m_z_reg     <= p_side[N].zs;
            m_roll_reg  <= p_side[N].roll;
            m_pitch_reg <= pitch_full[14:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_x_sample       = m_x_reg;
    assign m_y_sample       = m_y_reg;
    assign m_z_sample       = m_z_reg;
    assign m_roll_centideg  = m_roll_reg;
    assign m_pitch_centideg = m_pitch_reg;

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll_centideg >= -16'sd18000) && (m_roll_centideg <= 16'sd18000))
        else $error("roll outside half turn");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_centideg >= -15'sd9000) && (m_pitch_centideg <= 15'sd9000))
        else $error("pitch outside quarter turn");

    a_zero_roll_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_side_reg.zero |->
            (b_vec_reg.x == '0) && (b_vec_reg.y == '0) && (b_vec_reg.ang == '0))
        else $error("zero y and z gave a nonzero roll vector");

    a_zero_pitch_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_side_reg.zero |-> (c_vec_reg.x == '0) && (c_vec_reg.y == '0))
        else $error("pitch flagged zero with a nonzero vector");

endmodule
`default_nettype wire
